// ----- rtl/dfu_pkg.sv -----
// ----------------------------------------------------------------------------
// dfu_pkg
// Shared types, codes and limits of the DFU request handler.
// ----------------------------------------------------------------------------
package dfu_pkg;

    localparam int ALT_LIMIT = 16;
    localparam int MAX_CHUNK = 4096;

    localparam logic [12:0] DEFAULT_CHUNK = 13'd1024;
    localparam logic [12:0] CHUNK_CAP     = 13'(MAX_CHUNK);
    localparam logic [4:0]  TARGET_CAP    = 5'(ALT_LIMIT);

    // bState values
    localparam logic [3:0] ST_IDLE     = 4'd2;
    localparam logic [3:0] ST_DN_SYNC  = 4'd3;
    localparam logic [3:0] ST_DN_IDLE  = 4'd5;
    localparam logic [3:0] ST_MAN_SYNC = 4'd6;
    localparam logic [3:0] ST_UP_IDLE  = 4'd9;
    localparam logic [3:0] ST_ERROR    = 4'd10;

    // bStatus values
    localparam logic [3:0] STAT_OK        = 4'd0;
    localparam logic [3:0] STAT_ERR_WRITE = 4'd3;
    localparam logic [7:0] STAT_MAX       = 8'd15;

    // bRequest codes
    localparam logic [7:0] REQ_DETACH    = 8'd0;
    localparam logic [7:0] REQ_DNLOAD    = 8'd1;
    localparam logic [7:0] REQ_UPLOAD    = 8'd2;
    localparam logic [7:0] REQ_GETSTATUS = 8'd3;
    localparam logic [7:0] REQ_CLRSTATUS = 8'd4;
    localparam logic [7:0] REQ_GETSTATE  = 8'd5;
    localparam logic [7:0] REQ_ABORT     = 8'd6;

    localparam logic [12:0] STATUS_REPLY_LEN = 13'd6;
    localparam logic [12:0] STATE_REPLY_LEN  = 13'd1;

    // register addresses (word index)
    localparam logic REG_CHUNK  = 1'b0;
    localparam logic REG_TARGET = 1'b1;

    typedef struct packed {
        logic [12:0] chunk_size;
        logic [4:0]  target_count;
    } t_cfg;

    typedef struct packed {
        logic               kind;
        logic               class_request;
        logic [7:0]         request_code;
        logic [15:0]        block_number;
        logic [15:0]        request_length;
        logic signed [7:0]  write_outcome;
        logic [12:0]        read_count;
        logic [7:0]         alt_select;
    } t_req;

    typedef struct packed {
        logic [3:0] dev_state;
        logic [3:0] dev_status;
        logic [3:0] target;
    } t_ctx;

    typedef struct packed {
        logic        stall_res;
        logic [12:0] reply_length;
        logic        start_image;
        logic        finish_image;
        logic        write_strobe;
        logic        read_strobe;
        logic [27:0] image_address;
        logic [15:0] chunk_length;
    } t_res;

endpackage

// ----- rtl/dfu_request_state_machine_top.sv -----
// ----------------------------------------------------------------------------
// dfu_request_state_machine_top
// DFU 1.1 request handler: one request in, one reply with backend commands out.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+--------------------------
//  s_axis    | in        | i_s_axis_tvalid/o_..tready | request (tdata, tuser)
//  m_axis    | out       | o_m_axis_tvalid/i_..tready | reply and backend command
//  apb       | in        | psel/penable/pready        | chunk_size, target_count
//
//  Input register, then decode into the result register. One request per cycle
//  sustained while the output is not stalled; the DFU context updates when a
//  request moves into the result register, so the next one sees it directly.
//  Sync reset clears control and context; no clearing pass.
//  A stalled output holds the result register; the input register still takes
//  one request, and further requests wait on o_s_axis_tready.
// ----------------------------------------------------------------------------
module dfu_request_state_machine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] request_code, [23:8] block_number, [39:24] request_length,
    // [47:40] write_outcome, [60:48] read_count, [68:61] alt_select, rest zero
    input  logic [71:0] i_s_axis_tdata,
    // [0] kind, [1] class_request
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] stall_res, [13:1] reply_length, [17:14] state_code, [21:18] status_code,
    // [22] start_image, [23] finish_image, [24] write_strobe, [25] read_strobe,
    // [53:26] image_address, [69:54] chunk_length, [73:70] target_index, rest zero
    output logic [79:0] o_m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dfu_pkg::t_cfg cfg;
    dfu_pkg::t_req r_req;
    logic          r_in_valid;
    logic          r_out_valid;
    dfu_pkg::t_ctx r_ctx;
    dfu_pkg::t_ctx n_ctx;
    dfu_pkg::t_res r_res;
    dfu_pkg::t_res n_res;
    logic          out_free;
    logic          advance;

    dfu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dfu_step u_step (
        .i_cfg (cfg),
        .i_ctx (r_ctx),
        .i_req (r_req),
        .o_ctx (n_ctx),
        .o_res (n_res)
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_ctx.dev_state  <= dfu_pkg::ST_IDLE;
            r_ctx.dev_status <= dfu_pkg::STAT_OK;
            r_ctx.target     <= 4'd0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_ctx <= n_ctx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_req.kind           <= i_s_axis_tuser[0];
            r_req.class_request  <= i_s_axis_tuser[1];
            r_req.request_code   <= i_s_axis_tdata[7:0];
            r_req.block_number   <= i_s_axis_tdata[23:8];
            r_req.request_length <= i_s_axis_tdata[39:24];
            r_req.write_outcome  <= i_s_axis_tdata[47:40];
            r_req.read_count     <= i_s_axis_tdata[60:48];
            r_req.alt_select     <= i_s_axis_tdata[68:61];
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    // state, status and target in the result register are the context itself
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_ctx.target, r_res.chunk_length,
                              r_res.image_address, r_res.read_strobe,
                              r_res.write_strobe, r_res.finish_image,
                              r_res.start_image, r_ctx.dev_status,
                              r_ctx.dev_state, r_res.reply_length,
                              r_res.stall_res};

endmodule

// ----- rtl/dfu_cfg.sv -----
// ----------------------------------------------------------------------------
// dfu_cfg
// APB register file: transfer size and number of targets, with clamping.
// ----------------------------------------------------------------------------
module dfu_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output dfu_pkg::t_cfg o_cfg
);

    dfu_pkg::t_cfg r_cfg;
    dfu_pkg::t_cfg n_cfg;
    logic          wr_en;
    logic [12:0]   chunk_in;
    logic [4:0]    target_in;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb begin
        chunk_in  = pwdata[12:0];
        target_in = pwdata[4:0];
        if (chunk_in == 13'd0) begin
            chunk_in = dfu_pkg::DEFAULT_CHUNK;
        end else if (chunk_in > dfu_pkg::CHUNK_CAP) begin
            chunk_in = dfu_pkg::CHUNK_CAP;
        end
        if (target_in > dfu_pkg::TARGET_CAP) begin
            target_in = dfu_pkg::TARGET_CAP;
        end
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (paddr[2])
                dfu_pkg::REG_CHUNK:  n_cfg.chunk_size   = chunk_in;
                dfu_pkg::REG_TARGET: n_cfg.target_count = target_in;
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chunk_size   <= dfu_pkg::DEFAULT_CHUNK;
            r_cfg.target_count <= 5'd1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (paddr[2])
            dfu_pkg::REG_CHUNK:  prdata = {19'd0, r_cfg.chunk_size};
            dfu_pkg::REG_TARGET: prdata = {27'd0, r_cfg.target_count};
            default:             prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/dfu_step.sv -----
// ----------------------------------------------------------------------------
// dfu_step
// Request decode: next DFU context and backend commands for one request.
// ----------------------------------------------------------------------------
module dfu_step (
    input  dfu_pkg::t_cfg i_cfg,
    input  dfu_pkg::t_ctx i_ctx,
    input  dfu_pkg::t_req i_req,
    output dfu_pkg::t_ctx o_ctx,
    output dfu_pkg::t_res o_res
);

    logic [27:0] product;
    logic [12:0] want;
    logic [12:0] got;
    logic [7:0]  wraw;

    // 16-bit block times at most 4096 fits in 28 bits
    assign product = 28'(i_req.block_number) * 28'(i_cfg.chunk_size);
    assign wraw    = i_req.write_outcome;

    always_comb begin
        // chunk_size is at most 13 bits, so the min fits in 13 bits
        if ({3'd0, i_cfg.chunk_size} > i_req.request_length) begin
            want = i_req.request_length[12:0];
        end else begin
            want = i_cfg.chunk_size;
        end
        got = (i_req.read_count > want) ? want : i_req.read_count;
    end

    always_comb begin
        o_ctx = i_ctx;
        o_res = '0;
        if (i_req.kind) begin
            if ({3'd0, i_cfg.target_count} > i_req.alt_select) begin
                o_ctx.target     = i_req.alt_select[3:0];
                o_ctx.dev_state  = dfu_pkg::ST_IDLE;
                o_ctx.dev_status = dfu_pkg::STAT_OK;
            end
        end else if (!i_req.class_request) begin
            o_res.stall_res = 1'b1;
        end else begin
            unique case (i_req.request_code)
                dfu_pkg::REQ_DNLOAD: begin
                    if (i_req.request_length == 16'd0) begin
                        o_res.finish_image = 1'b1;
                        o_ctx.dev_state    = dfu_pkg::ST_MAN_SYNC;
                        o_ctx.dev_status   = dfu_pkg::STAT_OK;
                    end else begin
                        o_res.start_image   = (i_req.block_number == 16'd0);
                        o_res.write_strobe  = 1'b1;
                        o_res.image_address = product;
                        o_res.chunk_length  = i_req.request_length;
                        if (wraw == 8'd0) begin
                            o_ctx.dev_state  = dfu_pkg::ST_DN_SYNC;
                            o_ctx.dev_status = dfu_pkg::STAT_OK;
                        end else begin
                            // negative or above 15 reads as a generic write error
                            o_ctx.dev_state  = dfu_pkg::ST_ERROR;
                            o_ctx.dev_status = (wraw <= dfu_pkg::STAT_MAX) ?
                                               wraw[3:0] : dfu_pkg::STAT_ERR_WRITE;
                        end
                    end
                end
                dfu_pkg::REQ_UPLOAD: begin
                    o_res.read_strobe   = 1'b1;
                    o_res.image_address = product;
                    o_res.chunk_length  = {3'd0, want};
                    o_res.reply_length  = got;
                    o_ctx.dev_state     = (got != 13'd0) ? dfu_pkg::ST_UP_IDLE
                                                         : dfu_pkg::ST_IDLE;
                    o_ctx.dev_status    = dfu_pkg::STAT_OK;
                end
                dfu_pkg::REQ_GETSTATUS: begin
                    if (i_ctx.dev_state == dfu_pkg::ST_DN_SYNC) begin
                        o_ctx.dev_state = dfu_pkg::ST_DN_IDLE;
                    end else if (i_ctx.dev_state == dfu_pkg::ST_MAN_SYNC) begin
                        o_ctx.dev_state = dfu_pkg::ST_IDLE;
                    end
                    o_res.reply_length = dfu_pkg::STATUS_REPLY_LEN;
                end
                dfu_pkg::REQ_GETSTATE: begin
                    o_res.reply_length = dfu_pkg::STATE_REPLY_LEN;
                end
                dfu_pkg::REQ_CLRSTATUS, dfu_pkg::REQ_ABORT: begin
                    o_ctx.dev_state  = dfu_pkg::ST_IDLE;
                    o_ctx.dev_status = dfu_pkg::STAT_OK;
                end
                dfu_pkg::REQ_DETACH: begin
                    o_res.stall_res = 1'b0;
                end
                default: begin
                    o_res.stall_res = 1'b1;
                end
            endcase
        end
    end

endmodule
